// File: design/complex_fixed_point_alu_macros.svh
// Assertion macros shared by the complex ALU top level.
`ifndef COMPLEX_FIXED_POINT_ALU_MACROS_SVH
`define COMPLEX_FIXED_POINT_ALU_MACROS_SVH
// Implication checked every clock, disabled while in reset.
`define CFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset.
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: design/cfa_pkg.sv
// Types, constants and helpers for the complex fixed-point ALU.
package cfa_pkg;
    localparam int DataWidth = 16;
    localparam int FracBits  = 8;
    localparam int ProdWidth = 2 * DataWidth + 1;
    localparam int DenWidth  = 2 * DataWidth + 1;
    localparam int NumWidth  = ProdWidth + FracBits;
    localparam int QuoWidth  = NumWidth;
    localparam int Stages    = QuoWidth;
    localparam int Lat       = Stages + 3;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                        kind;
        logic signed [DataWidth-1:0] a_real;
        logic signed [DataWidth-1:0] a_imag;
        logic signed [DataWidth-1:0] b_real;
        logic signed [DataWidth-1:0] b_imag;
    } t_in;

    typedef struct packed {
        logic signed [DataWidth-1:0] result_real;
        logic signed [DataWidth-1:0] result_imag;
        logic                        overflow;
        logic                        divide_by_zero;
    } t_out;

    // Per-lane state moving down the cell chain
    typedef struct packed {
        logic                 neg;
        logic [NumWidth-1:0]  num;
        logic [QuoWidth-1:0]  quo;
        logic [DenWidth:0]    rem;
    } t_lane;

    // Operation state carried beside the lanes
    typedef struct packed {
        logic                         valid;
        t_kind                        kind;
        logic                         dbz;
        logic signed [NumWidth-1:0]   direct_r;
        logic signed [NumWidth-1:0]   direct_i;
        logic [DenWidth-1:0]          den;
        t_lane                        lr;
        t_lane                        li;
    } t_cell;

    // Saturate a wide value to DataWidth bits, returning overflow in the top bit
    function automatic logic [DataWidth:0] sat(input logic signed [NumWidth:0] x);
        logic signed [NumWidth:0] hi;
        logic signed [NumWidth:0] lo;
        hi = (NumWidth+1)'((1 << (DataWidth - 1)) - 1);
        lo = -hi - (NumWidth+1)'(1);
        if (x > hi) return {1'b1, hi[DataWidth-1:0]};
        if (x < lo) return {1'b1, lo[DataWidth-1:0]};
        return {1'b0, x[DataWidth-1:0]};
    endfunction
endpackage

// File: design/cfa_front.sv
// Front stages: products, sums and divide setup.
module cfa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cfa_pkg::t_in  i_data,
    output cfa_pkg::t_cell o_cell
);
    import cfa_pkg::*;

    logic                        r_v1;
    t_kind                       r_kind;
    logic signed [DataWidth:0]   r_sum_r, r_sum_i;
    logic signed [2*DataWidth-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [2*DataWidth-1:0] r_p_br2, r_p_bi2;
    t_cell                       r_cell;
    t_cell                       n_cell;
    logic signed [ProdWidth-1:0] c_re, c_im, c_mre, c_mim;
    logic [DenWidth-1:0]         c_den;
    logic [NumWidth-1:0]         c_nr, c_ni;

    // Stage 1: operand products, divisor squares and the add/sub results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_kind  <= i_data.kind;
            r_p_rr  <= i_data.a_real * i_data.b_real;
            r_p_ii  <= i_data.a_imag * i_data.b_imag;
            r_p_ri  <= i_data.a_real * i_data.b_imag;
            r_p_ir  <= i_data.a_imag * i_data.b_real;
            r_p_br2 <= i_data.b_real * i_data.b_real;
            r_p_bi2 <= i_data.b_imag * i_data.b_imag;
            if (i_data.kind == KIND_SUB) begin
                r_sum_r <= (DataWidth+1)'(i_data.a_real) - (DataWidth+1)'(i_data.b_real);
                r_sum_i <= (DataWidth+1)'(i_data.a_imag) - (DataWidth+1)'(i_data.b_imag);
            end else begin
                r_sum_r <= (DataWidth+1)'(i_data.a_real) + (DataWidth+1)'(i_data.b_real);
                r_sum_i <= (DataWidth+1)'(i_data.a_imag) + (DataWidth+1)'(i_data.b_imag);
            end
        end
    end

    // Stage 2: combine products, form magnitudes for the divider
    always_comb begin
        c_re  = ProdWidth'(r_p_rr) - ProdWidth'(r_p_ii);
        c_im  = ProdWidth'(r_p_ri) + ProdWidth'(r_p_ir);
        c_mre = ProdWidth'(r_p_rr) + ProdWidth'(r_p_ii);
        c_mim = ProdWidth'(r_p_ir) - ProdWidth'(r_p_ri);
        // |b|^2, never negative
        c_den = DenWidth'($unsigned(ProdWidth'(r_p_br2) + ProdWidth'(r_p_bi2)));
        c_nr  = c_mre[ProdWidth-1] ? NumWidth'(-c_mre) << FracBits
                                   : NumWidth'(c_mre) << FracBits;
        c_ni  = c_mim[ProdWidth-1] ? NumWidth'(-c_mim) << FracBits
                                   : NumWidth'(c_mim) << FracBits;
        n_cell          = '0;
        n_cell.valid    = r_v1;
        n_cell.kind     = r_kind;
        n_cell.den      = c_den;
        n_cell.dbz      = (r_kind == KIND_DIV) && (c_den == '0);
        case (r_kind)
            KIND_ADD, KIND_SUB: begin
                n_cell.direct_r = NumWidth'(r_sum_r);
                n_cell.direct_i = NumWidth'(r_sum_i);
            end
            KIND_MUL: begin
                n_cell.direct_r = NumWidth'(c_re >>> FracBits);
                n_cell.direct_i = NumWidth'(c_im >>> FracBits);
            end
            default: begin
                n_cell.direct_r = '0;
                n_cell.direct_i = '0;
            end
        endcase
        n_cell.lr.neg = c_mre[ProdWidth-1];
        n_cell.lr.num = c_nr;
        n_cell.li.neg = c_mim[ProdWidth-1];
        n_cell.li.num = c_ni;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

// File: design/cfa_cell.sv
// One restoring-division cell: one quotient bit per lane.
module cfa_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cfa_pkg::t_cell i_cell,
    output cfa_pkg::t_cell o_cell
);
    import cfa_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    function automatic t_lane step(input t_lane l, input logic [DenWidth-1:0] d);
        t_lane       o;
        logic [DenWidth:0] t;
        o = l;
        t = {l.rem[DenWidth-1:0], l.num[NumWidth-1]};
        o.num = l.num << 1;
        if (t >= {1'b0, d}) begin
            o.rem = t - {1'b0, d};
            o.quo = {l.quo[QuoWidth-2:0], 1'b1};
        end else begin
            o.rem = t;
            o.quo = {l.quo[QuoWidth-2:0], 1'b0};
        end
        return o;
    endfunction

    // Shift in one numerator bit, subtract when it fits
    always_comb begin
        n_cell    = i_cell;
        n_cell.lr = step(i_cell.lr, i_cell.den);
        n_cell.li = step(i_cell.li, i_cell.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule

// File: design/cfa_back.sv
// Final stage: sign restore, result select and saturation.
module cfa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cfa_pkg::t_cell i_cell,
    output logic           o_valid,
    output cfa_pkg::t_out  o_data
);
    import cfa_pkg::*;

    logic                     r_valid;
    t_out                     r_data;
    t_out                     n_data;
    logic signed [NumWidth:0] c_r, c_i;
    logic [DataWidth:0]       c_sr, c_si;

    always_comb begin
        if (i_cell.kind == KIND_DIV) begin
            c_r = i_cell.lr.neg ? -$signed({1'b0, i_cell.lr.quo}) : $signed({1'b0, i_cell.lr.quo});
            c_i = i_cell.li.neg ? -$signed({1'b0, i_cell.li.quo}) : $signed({1'b0, i_cell.li.quo});
        end else begin
            c_r = (NumWidth+1)'(i_cell.direct_r);
            c_i = (NumWidth+1)'(i_cell.direct_i);
        end
        c_sr = sat(c_r);
        c_si = sat(c_i);
        if (i_cell.dbz) begin
            n_data = '0;
            n_data.divide_by_zero = 1'b1;
        end else begin
            n_data.result_real    = c_sr[DataWidth-1:0];
            n_data.result_imag    = c_si[DataWidth-1:0];
            n_data.overflow       = c_sr[DataWidth] | c_si[DataWidth];
            n_data.divide_by_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_cell.valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: design/complex_fixed_point_alu.sv
// Top level of the complex fixed-point ALU.
// Complex Q8.8 ALU: add, subtract, multiply or divide two complex operands.
// Input channel i_valid/o_ready carries t_in; output channel o_valid/i_ready
// carries t_out. One result per transfer, in order.
// Pipeline: two front stages (products, then combine and divide setup), a
// chain of one cell per quotient bit (41 cells), and one output register,
// the same path for every operation.
// Throughput: one transfer per cycle; the whole pipe advances whenever the
// output register is empty or being taken.
// When the receiver stalls, the pipe holds and o_ready drops until the held
// result is taken; nothing is lost.
// Division truncates toward zero; a zero divisor yields zero parts with
// divide_by_zero set. Saturated parts set overflow.
// Reset (synchronous, active low) clears all valid bits; the data registers
// are not reset.
module complex_fixed_point_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cfa_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cfa_pkg::t_out o_data
);
    import cfa_pkg::*;
    `include "complex_fixed_point_alu_macros.svh"

    logic  w_en;
    t_cell w_chain [0:Stages];

    // Pipe moves when the output slot is free or draining
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    cfa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_cell  (w_chain[0])
    );

    for (genvar g = 0; g < Stages; g++) begin : g_cell
        cfa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    cfa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cell  (w_chain[Stages]),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    `CFA_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, o_valid && o_data.divide_by_zero, !o_data.overflow && o_data.result_real == '0 && o_data.result_imag == '0, "dbz result not clean")
    `CFA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data), "stalled result changed")
    `CFA_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_valid, o_ready, "pipe stalled with empty output")
endmodule

// File: tb/tb_top.sv
// Testbench for the complex fixed-point ALU: directed and randomized transfers checked against a predictor.
`timescale 1ns / 100ps
module tb_top;
    import cfa_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 100;
    localparam int RandomItems   = 1600;
    localparam int HoldOffStart  = 700;
    localparam int HoldOffLen    = 300;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_in   i_data;
    logic  o_valid;
    logic  i_ready;
    t_out  o_data;

    t_in   pending_ops[$];
    t_out  expected_results[$];
    int    mismatch_count;
    int    unexpected_count;
    int    sent_count;
    int    received_count;
    int    idle_cycles;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_off_cycles = 0;
    logic  hold_done = 1'b0;
    int    kind_count[4];
    int    ovf_count;
    int    dbz_count;

    // Transfer on the input side happened at the last rising edge
    logic o_ready_seen;

    complex_fixed_point_alu DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Clamp to 16 bits signed, flagging saturation
    function automatic logic signed [15:0] clamp16(input longint x, inout logic ovf);
        if (x > 32767) begin
            ovf = 1'b1;
            return 16'sh7fff;
        end
        if (x < -32768) begin
            ovf = 1'b1;
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    // Predict the ALU result for one operation
    function automatic t_out complex_result(input t_in op);
        t_out   r;
        longint ar, ai, br, bi, rr, ri, den;
        logic   ovf;
        ar = op.a_real;
        ai = op.a_imag;
        br = op.b_real;
        bi = op.b_imag;
        rr = 0;
        ri = 0;
        ovf = 1'b0;
        r = '0;
        case (op.kind)
            KIND_ADD: begin
                rr = ar + br;
                ri = ai + bi;
            end
            KIND_SUB: begin
                rr = ar - br;
                ri = ai - bi;
            end
            KIND_MUL: begin
                // arithmetic shift floors toward minus infinity
                rr = (ar * br - ai * bi) >>> FracBits;
                ri = (ar * bi + ai * br) >>> FracBits;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.divide_by_zero = 1'b1;
                    return r;
                end
                // longint division truncates toward zero
                rr = ((ar * br + ai * bi) * 256) / den;
                ri = ((ai * br - ar * bi) * 256) / den;
            end
        endcase
        r.result_real = clamp16(rr, ovf);
        r.result_imag = clamp16(ri, ovf);
        r.overflow    = ovf;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            3: return 16'($signed($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_op(input t_kind k, input int ar, input int ai,
                            input int br, input int bi);
        t_in op;
        op.kind   = k;
        op.a_real = 16'(ar);
        op.a_imag = 16'(ai);
        op.b_real = 16'(br);
        op.b_imag = 16'(bi);
        pending_ops.push_back(op);
    endtask

    // Driver: change inputs at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready_seen) begin
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_data  <= pending_ops.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready changes at the falling edge; one long hold-off mid-run
    always @(negedge i_clk) begin
        if (!hold_done && sent_count > HoldOffStart) begin
            hold_done       <= 1'b1;
            hold_off_cycles <= HoldOffLen;
            i_ready         <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready         <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: sample at the rising edge
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_ready_seen <= 1'b0;
            idle_cycles  <= 0;
        end else begin
            o_ready_seen <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                expected_results.push_back(complex_result(i_data));
                kind_count[i_data.kind]++;
                sent_count++;
            end
            if (o_valid && i_ready) begin
                received_count++;
                if (expected_results.size() == 0) begin
                    unexpected_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("ERROR: result with nothing expected: %p", o_data);
                end else begin
                    want = expected_results.pop_front();
                    ovf_count += want.overflow;
                    dbz_count += want.divide_by_zero;
                    if (o_data !== want) begin
                        mismatch_count++;
                        if (mismatch_count + unexpected_count <= 10)
                            $display({"ERROR: expected re=%0d im=%0d ovf=%b dbz=%b, ",
                                      "got re=%0d im=%0d ovf=%b dbz=%b"},
                                     want.result_real, want.result_imag, want.overflow,
                                     want.divide_by_zero, o_data.result_real,
                                     o_data.result_imag, o_data.overflow,
                                     o_data.divide_by_zero);
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && idle_cycles >= WatchdogLimit) begin
            $display("ERROR: no transfer for %0d cycles", WatchdogLimit);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    // Stimulus and phase control
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data  = '0;
        o_ready_seen = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 64;
        mismatch_count = 0;
        unexpected_count = 0;
        sent_count = 0;
        received_count = 0;
        ovf_count = 0;
        dbz_count = 0;
        idle_cycles = 0;
        for (int k = 0; k < 4; k++)
            kind_count[k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, each operation, saturation, zero divisor
        queue_op(KIND_ADD, 32767, -32768, 32767, -32768);
        queue_op(KIND_ADD, 100, -200, 300, 400);
        queue_op(KIND_SUB, -32768, 32767, 32767, -32768);
        queue_op(KIND_SUB, 0, 0, 1, -1);
        queue_op(KIND_MUL, 256, 0, 256, 0);
        queue_op(KIND_MUL, 32767, 32767, 32767, 32767);
        queue_op(KIND_MUL, -32768, -32768, -32768, 32767);
        queue_op(KIND_MUL, -1, 0, 1, 0);
        queue_op(KIND_MUL, -300, 77, 513, -129);
        queue_op(KIND_DIV, 512, 256, 0, 0);
        queue_op(KIND_DIV, -32768, -32768, 0, 0);
        queue_op(KIND_DIV, 256, 0, 256, 0);
        queue_op(KIND_DIV, 32767, 0, 1, 0);
        queue_op(KIND_DIV, -32768, -32768, -32768, -32768);
        queue_op(KIND_DIV, -1000, 333, 7, -3);
        queue_op(KIND_DIV, 1, 1, 32767, -32768);
        queue_op(KIND_DIV, -5, 3, 0, 1);
        queue_op(KIND_MUL, 0, 0, 0, 0);

        // The long receiver hold-off falls in the second phase
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 26 : 0;
            for (int n = 0; n < RandomItems / 3; n++) begin
                t_in op;
                op.kind   = t_kind'($urandom_range(0, 3));
                op.a_real = rand_part();
                op.a_imag = rand_part();
                op.b_real = rand_part();
                op.b_imag = rand_part();
                if (op.kind == KIND_DIV && $urandom_range(0, 15) == 0) begin
                    op.b_real = '0;
                    op.b_imag = '0;
                end
                pending_ops.push_back(op);
            end
            wait_drained();
        end
        repeat (DrainCycles) @(posedge i_clk);

        $display("Covered %0d transfers (add %0d, sub %0d, mul %0d, div %0d),",
                 sent_count, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("%0d saturated and %0d zero-divisor results, under three stall mixes.",
                 ovf_count, dbz_count);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0
            && received_count == sent_count) begin
            $display("*** PASSED ***");
        end else begin
            $display("ERROR: %0d mismatches, %0d unexpected, %0d missing",
                     mismatch_count, unexpected_count, expected_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
